FILE: sv/sprs_pkg.sv
package sprs_pkg;

  localparam int unsigned FLEN_W  = 32;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned X_W     = 13;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned BPP_W   = 42;   // file_length * 1000
  localparam int unsigned SIZE_W  = 43;   // (2^32) * 1000
  localparam int unsigned SUM_W   = 51;   // length * 255
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCALE_W-1:0] UNIT_SCALE = SCALE_W'(1000);
  localparam logic [X_W-1:0]     WIDTH_MAX  = {X_W{1'b1}};
  localparam logic [CNT_W-1:0]   STEPS_BPP  = CNT_W'(BPP_W);
  localparam logic [CNT_W-1:0]   STEPS_RUN  = CNT_W'(SIZE_W);
  localparam logic [CNT_W-1:0]   STEPS_COL  = CNT_W'(CH_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILE_LENGTH = 2'd0,
    REG_BAR_PIXELS  = 2'd1,
    REG_LEFT_ORIGIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        span_first;
    logic [31:0]        span_last;
    logic [COLOR_W-1:0] span_color;
    logic               final_span;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0]     run_x;
    logic [X_W-1:0]     run_width;
    logic [COLOR_W-1:0] run_color;
    logic               last_of_item;
    logic               bar_done;
  } out_item_t;

  typedef enum logic [1:0] {
    COL_RED,
    COL_GREEN,
    COL_BLUE
  } col_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_BPP_START,
    OP_BPP_SET,
    OP_RUN_START,
    OP_RUN_SET,
    OP_TAKE,
    OP_ACC,
    OP_COL_START,
    OP_COL_SET,
    OP_PART_SET,
    OP_PUSH,
    OP_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    col_t   col;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic bpp_ok;
    logic size_zero;
    logic take_path;
    logic full;
    logic partial_nz;
    logic final_span;
    logic push_ok;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BPP_START,
    S_BPP_WAIT,
    S_SCAN,
    S_ACC,
    S_RUN_WAIT,
    S_COL_START,
    S_COL_WAIT,
    S_PART,
    S_PUSH,
    S_FINAL,
    S_END
  } state_t;

endpackage

FILE: sv/sprs_div.sv
module sprs_div
  import sprs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dvd_in,
  input  logic [SIZE_W-1:0] rem_in,
  input  logic [SIZE_W-1:0] dsr_in,
  input  logic [CNT_W-1:0]  steps,
  output logic              busy,
  output logic [SUM_W-1:0]  quo,
  output logic [SIZE_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dsr_r, dsr_nxt;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              ge;

  // restoring step: quotient bits shift in at the bottom of the dividend
  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      dvd_nxt  = dvd_in;
      rem_nxt  = rem_in;
      dsr_nxt  = dsr_in;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = busy_r;
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

FILE: sv/sprs_datapath.sv
module sprs_datapath
  import sprs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FLEN_W-1:0]    cfg_data,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  logic [FLEN_W-1:0]  file_len_r, file_len_nxt;
  logic [PIX_W-1:0]   bar_pix_r, bar_pix_nxt;
  logic [PIX_W-1:0]   left_r, left_nxt;
  logic [BPP_W-1:0]   bpp_r, bpp_nxt;
  logic               bpp_ok_r, bpp_ok_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               final_r, final_nxt;
  logic [SIZE_W-1:0]  take_r, take_nxt;
  logic               full_r, full_nxt;
  logic [SIZE_W-1:0]  partial_r, partial_nxt;
  logic [SUM_W-1:0]   red_sum_r, red_sum_nxt;
  logic [SUM_W-1:0]   green_sum_r, green_sum_nxt;
  logic [SUM_W-1:0]   blue_sum_r, blue_sum_nxt;
  logic [CH_W-1:0]    red_q_r, red_q_nxt;
  logic [CH_W-1:0]    green_q_r, green_q_nxt;
  logic [CH_W-1:0]    blue_q_r, blue_q_nxt;
  logic [X_W-1:0]     next_x_r, next_x_nxt;
  out_item_t          res_r, res_nxt;
  out_item_t          pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_v_r, out_v_nxt;

  logic              div_start;
  logic [SUM_W-1:0]  div_dvd;
  logic [SIZE_W-1:0] div_rem_in;
  logic [SIZE_W-1:0] div_dsr;
  logic [CNT_W-1:0]  div_steps;
  logic              div_busy;
  logic [SUM_W-1:0]  div_quo;
  logic [SIZE_W-1:0] div_rem;

  logic [PIX_W-1:0]  pix_nz;
  logic [BPP_W-1:0]  units;
  logic [32:0]       span_len;
  logic [SIZE_W-1:0] room;
  logic [SUM_W-1:0]  col_sum;
  logic [X_W-1:0]    run_w;
  logic              out_free;

  sprs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .dvd_in (div_dvd),
    .rem_in (div_rem_in),
    .dsr_in (div_dsr),
    .steps  (div_steps),
    .busy   (div_busy),
    .quo    (div_quo),
    .rem    (div_rem)
  );

  assign pix_nz   = (bar_pix_r == '0) ? PIX_W'(1) : bar_pix_r;
  assign units    = BPP_W'(file_len_r) * BPP_W'(UNIT_SCALE);
  assign span_len = {1'b0, in_data.span_last} - {1'b0, in_data.span_first} + 33'd1;
  assign room     = {1'b0, bpp_r} - partial_r;
  assign run_w    = (div_quo[SIZE_W-1:0] > SIZE_W'(WIDTH_MAX)) ?
                    WIDTH_MAX : div_quo[X_W-1:0];
  assign out_free = !out_v_r || out_ready;

  always_comb begin
    unique case (cmd.col)
      COL_RED:   col_sum = red_sum_r;
      COL_GREEN: col_sum = green_sum_r;
      COL_BLUE:  col_sum = blue_sum_r;
      default:   col_sum = red_sum_r;
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    div_dvd    = {SIZE_W'(size_r), 8'b0};
    div_rem_in = '0;
    div_dsr    = {1'b0, bpp_r};
    div_steps  = STEPS_RUN;
    unique case (cmd.op)
      OP_BPP_START: begin
        div_start = 1'b1;
        div_dvd   = {units, {(SUM_W-BPP_W){1'b0}}};
        div_dsr   = SIZE_W'(pix_nz);
        div_steps = STEPS_BPP;
      end
      OP_RUN_START: begin
        div_start = 1'b1;
      end
      OP_COL_START: begin
        // average fits in 8 bits, so the high part of the sum is the start remainder
        div_start  = 1'b1;
        div_dvd    = {col_sum[CH_W-1:0], {(SUM_W-CH_W){1'b0}}};
        div_rem_in = col_sum[SUM_W-1:CH_W];
        div_dsr    = partial_r;
        div_steps  = STEPS_COL;
      end
      default: ;
    endcase
  end

  always_comb begin
    file_len_nxt  = file_len_r;
    bar_pix_nxt   = bar_pix_r;
    left_nxt      = left_r;
    bpp_nxt       = bpp_r;
    bpp_ok_nxt    = bpp_ok_r;
    size_nxt      = size_r;
    color_nxt     = color_r;
    final_nxt     = final_r;
    take_nxt      = take_r;
    full_nxt      = full_r;
    partial_nxt   = partial_r;
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    red_q_nxt     = red_q_r;
    green_q_nxt   = green_q_r;
    blue_q_nxt    = blue_q_r;
    next_x_nxt    = next_x_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_v_nxt     = out_v_r && !out_ready;

    unique case (cmd.op)
      OP_LOAD: begin
        size_nxt  = (in_data.span_last >= in_data.span_first) ?
                    SIZE_W'(span_len) * SIZE_W'(UNIT_SCALE) : '0;
        color_nxt = in_data.span_color;
        final_nxt = in_data.final_span;
      end
      OP_BPP_SET: begin
        bpp_nxt    = (div_quo[BPP_W-1:0] == '0) ? BPP_W'(1) : div_quo[BPP_W-1:0];
        bpp_ok_nxt = 1'b1;
      end
      OP_RUN_SET: begin
        res_nxt.run_x     = next_x_r;
        res_nxt.run_width = run_w;
        res_nxt.run_color = color_r;
        next_x_nxt        = next_x_r + run_w;
        size_nxt          = div_rem;
      end
      OP_TAKE: begin
        full_nxt = size_r >= room;
        take_nxt = (size_r < room) ? size_r : room;
      end
      OP_ACC: begin
        partial_nxt   = partial_r + take_r;
        size_nxt      = size_r - take_r;
        red_sum_nxt   = red_sum_r + SUM_W'(take_r) * SUM_W'(color_r[7:0]);
        green_sum_nxt = green_sum_r + SUM_W'(take_r) * SUM_W'(color_r[15:8]);
        blue_sum_nxt  = blue_sum_r + SUM_W'(take_r) * SUM_W'(color_r[23:16]);
      end
      OP_COL_SET: begin
        unique case (cmd.col)
          COL_RED:   red_q_nxt   = div_quo[CH_W-1:0];
          COL_GREEN: green_q_nxt = div_quo[CH_W-1:0];
          COL_BLUE:  blue_q_nxt  = div_quo[CH_W-1:0];
          default: ;
        endcase
      end
      OP_PART_SET: begin
        res_nxt.run_x     = next_x_r;
        res_nxt.run_width = X_W'(1);
        res_nxt.run_color = {blue_q_r, green_q_r, red_q_r};
        next_x_nxt        = next_x_r + X_W'(1);
        partial_nxt       = '0;
        red_sum_nxt       = '0;
        green_sum_nxt     = '0;
        blue_sum_nxt      = '0;
      end
      OP_PUSH: begin
        if (pend_v_r) begin
          out_nxt   = pend_r;
          out_v_nxt = 1'b1;
        end
        pend_nxt              = res_r;
        pend_nxt.last_of_item = 1'b0;
        pend_nxt.bar_done     = 1'b0;
        pend_v_nxt            = 1'b1;
      end
      OP_END: begin
        if (pend_v_r) begin
          out_nxt              = pend_r;
          out_nxt.last_of_item = 1'b1;
          out_nxt.bar_done     = final_r;
          out_v_nxt            = 1'b1;
        end
        pend_v_nxt = 1'b0;
        if (final_r) next_x_nxt = X_W'(left_r);
      end
      default: ;
    endcase

    // a write abandons the bar in progress
    if (cfg_we && cfg_index <= CFG_IDX_W'(REG_LEFT_ORIGIN)) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILE_LENGTH: file_len_nxt = cfg_data;
        REG_BAR_PIXELS:  bar_pix_nxt  = cfg_data[PIX_W-1:0];
        REG_LEFT_ORIGIN: left_nxt     = cfg_data[PIX_W-1:0];
        default: ;
      endcase
      bpp_ok_nxt    = 1'b0;
      partial_nxt   = '0;
      red_sum_nxt   = '0;
      green_sum_nxt = '0;
      blue_sum_nxt  = '0;
      next_x_nxt    = X_W'((cfg_reg_t'(cfg_index) == REG_LEFT_ORIGIN) ?
                           cfg_data[PIX_W-1:0] : left_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r  <= FLEN_W'(1);
      bar_pix_r   <= PIX_W'(1);
      left_r      <= '0;
      bpp_ok_r    <= 1'b0;
      partial_r   <= '0;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      next_x_r    <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      file_len_r  <= file_len_nxt;
      bar_pix_r   <= bar_pix_nxt;
      left_r      <= left_nxt;
      bpp_ok_r    <= bpp_ok_nxt;
      partial_r   <= partial_nxt;
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      next_x_r    <= next_x_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    bpp_r     <= bpp_nxt;
    size_r    <= size_nxt;
    color_r   <= color_nxt;
    final_r   <= final_nxt;
    take_r    <= take_nxt;
    full_r    <= full_nxt;
    red_q_r   <= red_q_nxt;
    green_q_r <= green_q_nxt;
    blue_q_r  <= blue_q_nxt;
    res_r     <= res_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign status.div_done   = !div_busy;
  assign status.bpp_ok     = bpp_ok_r;
  assign status.size_zero  = (size_r == '0);
  assign status.take_path  = (partial_r != '0) || (size_r < {1'b0, bpp_r});
  assign status.full       = full_r;
  assign status.partial_nz = (partial_r != '0);
  assign status.final_span = final_r;
  assign status.push_ok    = !pend_v_r || out_free;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: sv/sprs_ctrl.sv
module sprs_ctrl
  import sprs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  col_t   col_r, col_nxt;
  logic   flush_r, flush_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= COL_RED;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    flush_nxt = flush_r;
    cmd.op    = OP_NONE;
    cmd.col   = col_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          flush_nxt = 1'b0;
          state_nxt = status.bpp_ok ? S_SCAN : S_BPP_START;
        end
      end
      S_BPP_START: begin
        cmd.op    = OP_BPP_START;
        state_nxt = S_BPP_WAIT;
      end
      S_BPP_WAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_BPP_SET;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (status.size_zero) begin
          state_nxt = S_FINAL;
        end else if (status.take_path) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_ACC;
        end else begin
          cmd.op    = OP_RUN_START;
          state_nxt = S_RUN_WAIT;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (status.full) begin
          col_nxt   = COL_RED;
          state_nxt = S_COL_START;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_RUN_WAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_RUN_SET;
          state_nxt = S_PUSH;
        end
      end
      S_COL_START: begin
        cmd.op    = OP_COL_START;
        state_nxt = S_COL_WAIT;
      end
      S_COL_WAIT: begin
        if (status.div_done) begin
          cmd.op = OP_COL_SET;
          unique case (col_r)
            COL_RED: begin
              col_nxt   = COL_GREEN;
              state_nxt = S_COL_START;
            end
            COL_GREEN: begin
              col_nxt   = COL_BLUE;
              state_nxt = S_COL_START;
            end
            default: state_nxt = S_PART;
          endcase
        end
      end
      S_PART: begin
        cmd.op    = OP_PART_SET;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (status.push_ok) begin
          cmd.op    = OP_PUSH;
          state_nxt = flush_r ? S_END : S_SCAN;
        end
      end
      S_FINAL: begin
        if (status.final_span && status.partial_nz) begin
          flush_nxt = 1'b1;
          col_nxt   = COL_RED;
          state_nxt = S_COL_START;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (status.push_ok) begin
          cmd.op    = OP_END;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/span_to_pixel_resampler.sv
// Span to pixel resampler.
// Input channel (in_valid/in_ready/in_data) takes one span a transfer; the block
// works on one span at a time and raises in_ready only when idle.
// Output channel (out_valid/out_ready/out_data) gives zero to three runs per
// span; last_of_item marks the last run of a span, bar_done that of a final span.
// Registers take cfg_data at cfg_index on cfg_we; the user must write them only while
// idle (the block does not enforce it); any write to a known index drops the bar in progress.
// Timing: one serial restoring divider does all division, one quotient bit a
// cycle. Units per pixel are computed once after a register write; a full
// partial pixel takes three 8-bit divisions. A span may be empty, may only add
// to the partial pixel, or at most may recompute units per pixel and yield a
// partial pixel, a run and a final flush.
// A result is held one step back until the next one is known, so its
// last_of_item flag is right; the output register lets the next span start
// while a run waits. A stalled receiver holds the block at its next transfer.
// Reset: registers to file_length 1, bar_pixels 1, left_origin 0, bar cleared,
// no result pending.
module span_to_pixel_resampler
  import sprs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FLEN_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sprs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sprs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/sprs_checker.sv
module sprs_checker
  import sprs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bar_done |-> out_data.last_of_item)
    else $error("bar_done without last_of_item");

  a_width_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.run_width != '0)
    else $error("empty run");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // a span is taken only once the previous one is wound up, so accepting
  // right after an accept is impossible
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back span transfer");

endmodule

bind span_to_pixel_resampler sprs_checker u_sprs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
